@@ hdl/i2c_master_byte_sequencer_defines.svh @@
// assertion macros for the i2c master byte sequencer
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// checked outside reset
`define I2CMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define I2CMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/i2cms_pkg.sv @@
// types and constants shared by the i2c master byte sequencer
package i2cms_pkg;

  localparam int PRESCALE_WIDTH = 16;
  localparam int DATA_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [PRESCALE_WIDTH-1:0] UNIT_TICKS_RESET = PRESCALE_WIDTH'(1);

  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS = 1'd1;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  localparam logic [2:0] START_UNITS = 3'd4;
  localparam logic [2:0] BIT_UNITS = 3'd2;
  localparam logic [2:0] ACK_UNITS = 3'd1;

  // item from the input side, command in the low bits
  typedef struct packed {
    logic [2:0] pad;
    logic       sda_in;
    logic       ack_after_read;
    logic [7:0] tx_byte;
    logic [2:0] command;
  } in_item_t;

  // result item, scl_level in bit 0
  typedef struct packed {
    logic [1:0] pad;
    logic       ack_fail;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_item_t;

  typedef struct packed {
    logic [7:0]                ack_timeout;
    logic [PRESCALE_WIDTH-1:0] unit_ticks;
  } cfg_t;

endpackage

@@ hdl/i2cms_core.sv @@
// bus sequencer state and per-tick next-state logic
module i2cms_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  i2cms_pkg::in_item_t   item,
  input  i2cms_pkg::cfg_t       cfg,
  output i2cms_pkg::res_item_t  res
);
  import i2cms_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_A  = 4'd1;
  localparam logic [3:0] PH_START_B  = 4'd2;
  localparam logic [3:0] PH_STOP_A   = 4'd3;
  localparam logic [3:0] PH_STOP_B   = 4'd4;
  localparam logic [3:0] PH_WR_SETUP = 4'd5;
  localparam logic [3:0] PH_WR_HIGH  = 4'd6;
  localparam logic [3:0] PH_WR_LOW   = 4'd7;
  localparam logic [3:0] PH_ACK_REL  = 4'd8;
  localparam logic [3:0] PH_ACK_HIGH = 4'd9;
  localparam logic [3:0] PH_ACK_POLL = 4'd10;
  localparam logic [3:0] PH_RD_LOW   = 4'd11;
  localparam logic [3:0] PH_RD_HIGH  = 4'd12;
  localparam logic [3:0] PH_RA_LOW   = 4'd13;
  localparam logic [3:0] PH_RA_HIGH  = 4'd14;

  logic [3:0] phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [PRESCALE_WIDTH-1:0] unit_count, unit_count_next;
  logic [2:0] step_units, step_units_next;
  logic [7:0] wait_count, wait_count_next;
  logic [7:0] rx_reg, rx_reg_next;
  logic scl_reg, scl_reg_next;
  logic sda_reg, sda_reg_next;
  logic sda_oe_reg, sda_oe_reg_next;
  logic fail_flag, fail_flag_next;
  logic ack_choice, ack_choice_next;
  logic done;

  logic [PRESCALE_WIDTH:0]   cnt_inc;
  logic [PRESCALE_WIDTH-1:0] unit_len;
  logic [2:0]                step_left;
  logic [3:0]                bc_inc;

  always_comb begin
    phase_next = phase;
    bit_count_next = bit_count;
    shift_reg_next = shift_reg;
    unit_count_next = unit_count;
    step_units_next = step_units;
    wait_count_next = wait_count;
    rx_reg_next = rx_reg;
    scl_reg_next = scl_reg;
    sda_reg_next = sda_reg;
    sda_oe_reg_next = sda_oe_reg;
    fail_flag_next = fail_flag;
    ack_choice_next = ack_choice;
    done = 1'b0;
    cnt_inc = {1'b0, unit_count} + (PRESCALE_WIDTH+1)'(1);
    unit_len = (cfg.unit_ticks == '0) ? PRESCALE_WIDTH'(1) : cfg.unit_ticks;
    step_left = step_units;
    bc_inc = bit_count + 4'd1;

    if (phase == PH_IDLE) begin
      case (item.command)
        CMD_START: begin
          sda_oe_reg_next = 1'b1;
          sda_reg_next = 1'b1;
          scl_reg_next = 1'b1;
          step_units_next = START_UNITS;
          unit_count_next = '0;
          phase_next = PH_START_A;
        end
        CMD_STOP: begin
          sda_oe_reg_next = 1'b1;
          scl_reg_next = 1'b0;
          sda_reg_next = 1'b0;
          step_units_next = START_UNITS;
          unit_count_next = '0;
          phase_next = PH_STOP_A;
        end
        CMD_WRITE: begin
          fail_flag_next = 1'b0;
          shift_reg_next = item.tx_byte;
          bit_count_next = '0;
          sda_oe_reg_next = 1'b1;
          scl_reg_next = 1'b0;
          sda_reg_next = item.tx_byte[7];
          step_units_next = BIT_UNITS;
          unit_count_next = '0;
          phase_next = PH_WR_SETUP;
        end
        CMD_READ: begin
          ack_choice_next = item.ack_after_read;
          shift_reg_next = '0;
          bit_count_next = '0;
          sda_oe_reg_next = 1'b0;
          scl_reg_next = 1'b0;
          step_units_next = BIT_UNITS;
          unit_count_next = '0;
          phase_next = PH_RD_LOW;
        end
        default: begin
        end
      endcase
    end else if (phase == PH_ACK_POLL) begin
      if (!item.sda_in) begin
        scl_reg_next = 1'b0;
        fail_flag_next = 1'b0;
        phase_next = PH_IDLE;
        done = 1'b1;
      end else if (wait_count >= cfg.ack_timeout) begin
        fail_flag_next = 1'b1;
        sda_oe_reg_next = 1'b1;
        scl_reg_next = 1'b0;
        sda_reg_next = 1'b0;
        step_units_next = START_UNITS;
        unit_count_next = '0;
        phase_next = PH_STOP_A;
      end else begin
        wait_count_next = wait_count + 8'd1;
      end
    end else begin
      if (cnt_inc >= {1'b0, unit_len}) begin
        unit_count_next = '0;
        if (step_units != '0) begin
          step_left = step_units - 3'd1;
        end
      end else begin
        unit_count_next = cnt_inc[PRESCALE_WIDTH-1:0];
      end
      step_units_next = step_left;
      if (step_left == '0) begin
        case (phase)
          PH_START_A: begin
            sda_reg_next = 1'b0;
            step_units_next = START_UNITS;
            unit_count_next = '0;
            phase_next = PH_START_B;
          end
          PH_START_B: begin
            scl_reg_next = 1'b0;
            phase_next = PH_IDLE;
            done = 1'b1;
          end
          PH_STOP_A: begin
            scl_reg_next = 1'b1;
            sda_reg_next = 1'b1;
            step_units_next = START_UNITS;
            unit_count_next = '0;
            phase_next = PH_STOP_B;
          end
          PH_STOP_B: begin
            phase_next = PH_IDLE;
            done = 1'b1;
          end
          PH_WR_SETUP: begin
            scl_reg_next = 1'b1;
            step_units_next = BIT_UNITS;
            unit_count_next = '0;
            phase_next = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            scl_reg_next = 1'b0;
            step_units_next = BIT_UNITS;
            unit_count_next = '0;
            phase_next = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            bit_count_next = bc_inc;
            shift_reg_next = {shift_reg[6:0], 1'b0};
            unit_count_next = '0;
            if (bc_inc >= 4'd8) begin
              sda_oe_reg_next = 1'b0;
              sda_reg_next = 1'b1;
              wait_count_next = '0;
              step_units_next = ACK_UNITS;
              phase_next = PH_ACK_REL;
            end else begin
              sda_reg_next = shift_reg[6];
              step_units_next = BIT_UNITS;
              phase_next = PH_WR_SETUP;
            end
          end
          PH_ACK_REL: begin
            scl_reg_next = 1'b1;
            step_units_next = ACK_UNITS;
            unit_count_next = '0;
            phase_next = PH_ACK_HIGH;
          end
          PH_ACK_HIGH: begin
            phase_next = PH_ACK_POLL;
          end
          PH_RD_LOW: begin
            scl_reg_next = 1'b1;
            shift_reg_next = {shift_reg[6:0], item.sda_in};
            step_units_next = ACK_UNITS;
            unit_count_next = '0;
            phase_next = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            bit_count_next = bc_inc;
            scl_reg_next = 1'b0;
            step_units_next = BIT_UNITS;
            unit_count_next = '0;
            if (bc_inc >= 4'd8) begin
              rx_reg_next = shift_reg;
              sda_oe_reg_next = 1'b1;
              sda_reg_next = ~ack_choice;
              phase_next = PH_RA_LOW;
            end else begin
              phase_next = PH_RD_LOW;
            end
          end
          PH_RA_LOW: begin
            scl_reg_next = 1'b1;
            step_units_next = BIT_UNITS;
            unit_count_next = '0;
            phase_next = PH_RA_HIGH;
          end
          PH_RA_HIGH: begin
            scl_reg_next = 1'b0;
            phase_next = PH_IDLE;
            done = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
            done = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bit_count <= '0;
      shift_reg <= '0;
      unit_count <= '0;
      step_units <= '0;
      wait_count <= '0;
      rx_reg <= '0;
      scl_reg <= 1'b1;
      sda_reg <= 1'b1;
      sda_oe_reg <= 1'b1;
      fail_flag <= 1'b0;
      ack_choice <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      bit_count <= bit_count_next;
      shift_reg <= shift_reg_next;
      unit_count <= unit_count_next;
      step_units <= step_units_next;
      wait_count <= wait_count_next;
      rx_reg <= rx_reg_next;
      scl_reg <= scl_reg_next;
      sda_reg <= sda_reg_next;
      sda_oe_reg <= sda_oe_reg_next;
      fail_flag <= fail_flag_next;
      ack_choice <= ack_choice_next;
    end
  end

  always_comb begin
    res = '0;
    res.scl_level = scl_reg_next;
    res.sda_level = sda_reg_next;
    res.sda_drive = sda_oe_reg_next;
    res.busy_res = (phase_next != PH_IDLE);
    res.done_res = done;
    res.rx_byte = rx_reg_next;
    res.ack_fail = fail_flag_next;
  end

endmodule

@@ hdl/i2c_master_byte_sequencer.sv @@
// i2c master byte sequencer top level: input register, config, result register
//
//   channel   direction  contents
//   s_axis    in         one bus tick: command, tx_byte, ack_after_read, sda_in
//   m_axis    out        line levels, busy, done, rx_byte, ack_fail after the tick
//   cfg       in         register writes: ack_timeout, unit_ticks
//
// one item per cycle sustained while m_axis_tready stays high; a stalled output holds the flow
// path: input register, then next-state logic into the result register
// rst clears control state, lines reset high and driven, ack_timeout 250, unit_ticks 1
// a stalled output holds its item; the input register keeps taking items until both fill
module i2c_master_byte_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // command[2:0], tx_byte[10:3], ack_after_read[11], sda_in[12], zero[15:13]
  input  logic [i2cms_pkg::DATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
  // rx_byte[12:5], ack_fail[13], zero[15:14]
  output logic [i2cms_pkg::DATA_W-1:0]  m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cms_pkg::*;
  `include "i2c_master_byte_sequencer_defines.svh"

  cfg_t      cfg;
  logic      in_valid;
  in_item_t  in_reg;
  logic      out_valid;
  res_item_t out_reg;
  res_item_t res;
  logic      step;

  assign step = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout <= ACK_TIMEOUT_RESET;
      cfg.unit_ticks <= UNIT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_data[7:0];
        REG_UNIT_TICKS: cfg.unit_ticks <= cfg_data[PRESCALE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_reg <= in_item_t'(s_axis_tdata);
    end
  end

  i2cms_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_reg),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = DATA_W'(out_reg);

  `I2CMS_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !in_valid, "pipeline not empty after reset")
  `I2CMS_ASSERT(a_ready_only_full, !s_axis_tready |-> in_valid && out_valid && !m_axis_tready, "input stalled while pipeline can move")
  `I2CMS_ASSERT(a_done_not_busy, step && res.done_res |-> !res.busy_res, "done reported while still busy")
  `I2CMS_ASSERT(a_step_fills_out, step |=> out_valid, "result register not loaded after a step")

endmodule
